>>> hdl/bdma_pkg.sv
`timescale 1ns / 1ps

package bdma_pkg;

  // Main-CPU address map
  localparam logic [15:0] ADDR_ROM_LO     = 16'ha000;
  localparam logic [15:0] ADDR_ROM_HI     = 16'hdfff;
  localparam logic [15:0] ADDR_DMA_LO     = 16'he000;
  localparam logic [15:0] ADDR_DMA_HI     = 16'he003;
  localparam logic [15:0] ADDR_PLAYER     = 16'hf000;
  localparam logic [15:0] ADDR_SOUND      = 16'hf000;
  localparam logic [15:0] ADDR_CHAR_BANK  = 16'hf080;
  localparam logic [15:0] ADDR_DMA_START  = 16'hf083;
  localparam logic [15:0] ADDR_BANK_LO    = 16'hf084;
  localparam logic [15:0] ADDR_BANK_HI    = 16'hf086;
  localparam logic [15:0] ADDR_SYSTEM     = 16'hf100;
  localparam logic [15:0] ADDR_NMI        = 16'hf101;
  localparam logic [15:0] ADDR_PROT_LO    = 16'hf102;
  localparam logic [15:0] ADDR_PROT_HI    = 16'hf105;
  localparam logic [15:0] ADDR_DIP_A      = 16'hf180;
  localparam logic [15:0] ADDR_DIP_B      = 16'hf200;

  localparam logic [7:0] SYS_MASK  = 8'h9f;
  localparam logic [9:0] SIZE_MASK = 10'h3ff;
  localparam logic [1:0] BANK_APPLY_BIT = 2'd2;
  localparam logic [2:0] BANK_MAX = 3'd2;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Configuration register indexes (paddr[2])
  localparam logic REG_DIP_A = 1'b0;
  localparam logic REG_DIP_B = 1'b1;

  // Protection table, bits 1:0 of each entry
  localparam logic [1:0] PROT_TABLE [16] = '{
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd0,
    2'd2, 2'd2, 2'd2, 2'd0, 2'd3, 2'd1, 2'd0, 2'd3
  };

  typedef struct packed {
    logic        mode;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [7:0]  player_buttons;
    logic [7:0]  system_buttons;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        dma_go;
    logic [15:0] dma_source;
    logic [15:0] dma_dest;
    logic [10:0] dma_count;
    logic [1:0]  rom_bank;
    logic [7:0]  char_bank_out;
    logic        sound_strobe;
    logic [7:0]  sound_byte;
    logic        nmi_on;
  } out_t;

  typedef struct packed {
    logic [7:0] dip_a;
    logic [7:0] dip_b;
  } dip_t;

endpackage

>>> hdl/bdma_apb.sv
`timescale 1ns / 1ps

module bdma_apb (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output bdma_pkg::dip_t     dips
);

  logic wr;

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dips <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        bdma_pkg::REG_DIP_A: dips.dip_a <= pwdata[7:0];
        bdma_pkg::REG_DIP_B: dips.dip_b <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bdma_pkg::REG_DIP_A: prdata = {24'd0, dips.dip_a};
      bdma_pkg::REG_DIP_B: prdata = {24'd0, dips.dip_b};
      default:             prdata = '0;
    endcase
  end

endmodule

>>> hdl/bdma_core.sv
`timescale 1ns / 1ps

module bdma_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  bdma_pkg::in_t   item,
  input  bdma_pkg::dip_t  dips,
  output bdma_pkg::out_t  result
);

  logic [7:0] dma_regs [8];
  logic [7:0] dma_regs_next [8];
  logic [3:0] dma_toggle, dma_toggle_next;
  logic [2:0] bank_bits, bank_bits_next;
  logic [1:0] mapped_bank, mapped_bank_next;
  logic [7:0] char_bank_reg, char_bank_reg_next;
  logic [7:0] sound_latch_reg, sound_latch_reg_next;
  logic [7:0] nmi_reg, nmi_reg_next;
  logic [3:0] prot_index, prot_index_next;

  logic [15:0] addr;
  logic [7:0]  data;
  logic [1:0]  port;
  logic [15:0] bank_off;
  logic [15:0] prot_off;
  logic [9:0]  size;

  assign addr     = item.bus_address;
  assign data     = item.write_byte;
  assign port     = addr[1:0];
  assign bank_off = addr - bdma_pkg::ADDR_BANK_LO;
  assign prot_off = addr - bdma_pkg::ADDR_PROT_LO;
  assign size     = {dma_regs[3][1:0], dma_regs[2]} & bdma_pkg::SIZE_MASK;

  always_comb begin
    dma_regs_next        = dma_regs;
    dma_toggle_next      = dma_toggle;
    bank_bits_next       = bank_bits;
    mapped_bank_next     = mapped_bank;
    char_bank_reg_next   = char_bank_reg;
    sound_latch_reg_next = sound_latch_reg;
    nmi_reg_next         = nmi_reg;
    prot_index_next      = prot_index;
    result               = '0;

    if (item.mode == bdma_pkg::MODE_READ) begin
      case (addr)
        bdma_pkg::ADDR_PLAYER: result.read_byte = item.player_buttons;
        bdma_pkg::ADDR_SYSTEM: result.read_byte = (item.system_buttons & bdma_pkg::SYS_MASK) |
                                 {1'b0, bdma_pkg::PROT_TABLE[prot_index], 5'd0};
        bdma_pkg::ADDR_DIP_A:  result.read_byte = dips.dip_a;
        bdma_pkg::ADDR_DIP_B:  result.read_byte = dips.dip_b;
        default: ;
      endcase
    end else if (addr >= bdma_pkg::ADDR_ROM_LO && addr <= bdma_pkg::ADDR_ROM_HI) begin
      // banked ROM window: drop the write
    end else if (addr >= bdma_pkg::ADDR_DMA_LO && addr <= bdma_pkg::ADDR_DMA_HI) begin
      dma_regs_next[{port, dma_toggle[port]}] = data;
      dma_toggle_next[port] = ~dma_toggle[port];
    end else if (addr == bdma_pkg::ADDR_SOUND) begin
      sound_latch_reg_next = data;
      result.sound_strobe  = 1'b1;
    end else if (addr == bdma_pkg::ADDR_CHAR_BANK) begin
      char_bank_reg_next = data;
    end else if (addr == bdma_pkg::ADDR_DMA_START) begin
      if (data == 8'd0) begin
        result.dma_go     = 1'b1;
        result.dma_source = {dma_regs[1], dma_regs[0]};
        result.dma_count  = {1'b0, size} + 11'd1;
        result.dma_dest   = {dma_regs[5], dma_regs[4]};
        dma_toggle_next   = '0;
      end
    end else if (addr >= bdma_pkg::ADDR_BANK_LO && addr <= bdma_pkg::ADDR_BANK_HI) begin
      bank_bits_next[bank_off[1:0]] = data[0];
      // only the last bit applies the bank, out-of-range values map to bank 0
      if (bank_off[1:0] == bdma_pkg::BANK_APPLY_BIT) begin
        if (bank_bits_next > bdma_pkg::BANK_MAX) begin
          bank_bits_next = '0;
        end
        mapped_bank_next = bank_bits_next[1:0];
      end
    end else if (addr == bdma_pkg::ADDR_NMI) begin
      nmi_reg_next = data;
    end else if (addr >= bdma_pkg::ADDR_PROT_LO && addr <= bdma_pkg::ADDR_PROT_HI) begin
      prot_index_next[prot_off[1:0]] = data[0];
    end

    result.rom_bank      = mapped_bank_next;
    result.char_bank_out = char_bank_reg_next;
    result.sound_byte    = sound_latch_reg_next;
    result.nmi_on        = |nmi_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dma_regs        <= '{default: '0};
      dma_toggle      <= '0;
      bank_bits       <= '0;
      mapped_bank     <= '0;
      char_bank_reg   <= '0;
      sound_latch_reg <= '0;
      nmi_reg         <= '0;
      prot_index      <= '0;
    end else if (fire) begin
      dma_regs        <= dma_regs_next;
      dma_toggle      <= dma_toggle_next;
      bank_bits       <= bank_bits_next;
      mapped_bank     <= mapped_bank_next;
      char_bank_reg   <= char_bank_reg_next;
      sound_latch_reg <= sound_latch_reg_next;
      nmi_reg         <= nmi_reg_next;
      prot_index      <= prot_index_next;
    end
  end

endmodule

>>> hdl/board_io_dma_bank_registers.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// in        in_valid / in_ready     in_data  (bdma_pkg::in_t, one bus access)
// out       out_valid / out_ready   out_data (bdma_pkg::out_t, one result word)
// cfg       psel/penable/pwrite     paddr[2:0], pwdata, prdata (DIP switch banks)
//
// Each access is latched in an input register, decoded and written to the
// result register, one word per cycle while the output is not stalled.
// The result register frees up in the same cycle out_ready takes its word, so
// a stall on the output fills the input register and then drops in_ready.
// rst is synchronous; it clears core and DIP state and both valid flags only.
module board_io_dma_bank_registers (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bdma_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bdma_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  bdma_pkg::dip_t dips;
  bdma_pkg::in_t  item;
  bdma_pkg::out_t result;
  logic           item_valid;
  logic           fire;

  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  bdma_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dips    (dips)
  );

  bdma_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .dips   (dips),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (fire) begin
        item_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (fire) begin
      out_data <= result;
    end
  end

endmodule
